### sv/spmc_pkg.sv
// Shared types, codes and constants of the sensor power-mode controller.
`timescale 1ns / 1ps
package spmc_pkg;

  // Input action codes.
  localparam logic [2:0] ACT_TICK     = 3'd0;
  localparam logic [2:0] ACT_MOTION   = 3'd1;
  localparam logic [2:0] ACT_COMPLETE = 3'd2;
  localparam logic [2:0] ACT_STREAM   = 3'd3;
  localparam logic [2:0] ACT_QUERY    = 3'd4;

  // Mode codes as they appear on the result channel.
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_BURST  = 2'd1;
  localparam logic [1:0] MODE_ACTIVE = 2'd2;

  // Sensor command codes.
  localparam logic [1:0] CMD_NONE     = 2'd0;
  localparam logic [1:0] CMD_LOWPOWER = 2'd1;
  localparam logic [1:0] CMD_ACTIVE   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BURST_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_HB_PERIOD     = 2'd1;
  localparam logic [1:0] CFG_MOTION_WAKE   = 2'd2;

  localparam logic [15:0] TIMEOUT_RESET   = 16'd4500;
  localparam logic [31:0] HEARTBEAT_RESET = 32'd60000;
  localparam logic [9:0]  MS_PER_S_LAST   = 10'd999;
  localparam logic [7:0]  MOVEMENT_MAX    = 8'd254;

  // The 32-bit millisecond uptime wraps after 4294967 s and 295 ms.
  localparam logic [22:0] UPTIME_SEC_WRAP = 23'd4294967;
  localparam logic [9:0]  UPTIME_SUB_WRAP = 10'd295;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_BURST  = 3'b010,
    ST_ACTIVE = 3'b100
  } mode_state_t;

  typedef struct packed {
    logic [2:0] action;
    logic       streaming_on;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  sensor_cmd;
    logic        clear_latch;
    logic        discard_samples;
    logic        reset_stream;
    logic [22:0] uptime_sec;
    logic [31:0] idle_total;
    logic [31:0] burst_total;
    logic [31:0] active_total;
    logic [15:0] burst_count;
    logic [15:0] motion_count;
    logic [7:0]  movement_byte;
  } out_item_t;

  typedef struct packed {
    logic [15:0] burst_timeout_ticks;
    logic [31:0] heartbeat_period_ticks;
    logic        motion_wake_enable;
  } cfg_regs_t;

  // Uptime is kept as whole seconds plus milliseconds within the second.
  typedef struct packed {
    mode_state_t mode;
    logic        streaming;
    logic        timeout_armed;
    logic [15:0] timeout_left;
    logic [31:0] heartbeat_left;
    logic [9:0]  ms_sub;
    logic [22:0] uptime_sec;
    logic [31:0] idle_ticks;
    logic [31:0] burst_ticks;
    logic [31:0] active_ticks;
    logic [15:0] bursts_seen;
    logic [15:0] motions_seen;
  } ctl_state_t;

  function automatic logic [1:0] mode_code(mode_state_t m);
    logic [1:0] code;
    unique case (m)
      ST_IDLE:   code = MODE_IDLE;
      ST_BURST:  code = MODE_BURST;
      ST_ACTIVE: code = MODE_ACTIVE;
      default:   code = MODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

### sv/spmc_cfg.sv
// Configuration register file of the sensor power-mode controller.
`timescale 1ns / 1ps
module spmc_cfg
  import spmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_regs_t   cfg_o
);

  cfg_regs_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.burst_timeout_ticks    <= TIMEOUT_RESET;
      cfg_r.heartbeat_period_ticks <= HEARTBEAT_RESET;
      cfg_r.motion_wake_enable     <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BURST_TIMEOUT: cfg_r.burst_timeout_ticks    <= cfg_data[15:0];
        CFG_HB_PERIOD:     cfg_r.heartbeat_period_ticks <= cfg_data;
        CFG_MOTION_WAKE:   cfg_r.motion_wake_enable     <= cfg_data[0];
        default: begin
          // Writes beyond the register list are dropped.
        end
      endcase
    end
  end

endmodule

### sv/spmc_step.sv
// Next-state and result logic for one input item.
`timescale 1ns / 1ps
module spmc_step
  import spmc_pkg::*;
(
  input  ctl_state_t st_i,
  input  cfg_regs_t  cfg_i,
  input  in_item_t   item_i,
  output ctl_state_t st_o,
  output out_item_t  res_o
);

  ctl_state_t ns;
  logic [1:0] cmd;
  logic       latch;
  logic       disc;
  logic       strm;

  always_comb begin
    ns    = st_i;
    cmd   = CMD_NONE;
    latch = 1'b0;
    disc  = 1'b0;
    strm  = 1'b0;

    unique case (item_i.action)
      ACT_TICK: begin
        unique case (st_i.mode)
          ST_IDLE:   ns.idle_ticks   = st_i.idle_ticks + 32'd1;
          ST_BURST:  ns.burst_ticks  = st_i.burst_ticks + 32'd1;
          ST_ACTIVE: ns.active_ticks = st_i.active_ticks + 32'd1;
          default:   ns.idle_ticks   = st_i.idle_ticks;
        endcase

        if (st_i.uptime_sec == UPTIME_SEC_WRAP && st_i.ms_sub == UPTIME_SUB_WRAP) begin
          ns.uptime_sec = '0;
          ns.ms_sub     = '0;
        end else if (st_i.ms_sub == MS_PER_S_LAST) begin
          ns.uptime_sec = st_i.uptime_sec + 23'd1;
          ns.ms_sub     = '0;
        end else begin
          ns.ms_sub     = st_i.ms_sub + 10'd1;
        end

        if (st_i.timeout_armed) begin
          if (st_i.timeout_left <= 16'd1) begin
            ns.timeout_left  = '0;
            ns.timeout_armed = 1'b0;
            if (st_i.mode == ST_BURST && !st_i.streaming) begin
              ns.mode = ST_IDLE;
              cmd     = CMD_LOWPOWER;
              latch   = 1'b1;
            end
          end else begin
            ns.timeout_left = st_i.timeout_left - 16'd1;
          end
        end

        // The heartbeat sees the mode that the timeout may just have entered.
        if (st_i.heartbeat_left <= 32'd1) begin
          ns.heartbeat_left = cfg_i.heartbeat_period_ticks;
          if (ns.mode == ST_IDLE) begin
            ns.mode          = ST_BURST;
            ns.bursts_seen   = st_i.bursts_seen + 16'd1;
            ns.timeout_armed = 1'b1;
            ns.timeout_left  = cfg_i.burst_timeout_ticks;
            disc             = 1'b1;
            cmd              = CMD_ACTIVE;
          end
        end else begin
          ns.heartbeat_left = st_i.heartbeat_left - 32'd1;
        end
      end

      ACT_MOTION: begin
        if (cfg_i.motion_wake_enable) begin
          ns.motions_seen = st_i.motions_seen + 16'd1;
          if (st_i.mode == ST_IDLE) begin
            ns.mode          = ST_BURST;
            ns.bursts_seen   = st_i.bursts_seen + 16'd1;
            ns.timeout_armed = 1'b1;
            ns.timeout_left  = cfg_i.burst_timeout_ticks;
            disc             = 1'b1;
            cmd              = CMD_ACTIVE;
          end
        end
      end

      ACT_COMPLETE: begin
        if (st_i.mode == ST_BURST && !st_i.streaming) begin
          ns.timeout_armed = 1'b0;
          ns.mode          = ST_IDLE;
          cmd              = CMD_LOWPOWER;
          latch            = 1'b1;
        end
      end

      ACT_STREAM: begin
        ns.streaming = item_i.streaming_on;
        if (item_i.streaming_on) begin
          ns.timeout_armed = 1'b0;
          strm             = 1'b1;
          if (st_i.mode != ST_ACTIVE) begin
            ns.mode = ST_ACTIVE;
            disc    = 1'b1;
            cmd     = CMD_ACTIVE;
          end
        end else if (st_i.mode != ST_IDLE) begin
          ns.mode = ST_IDLE;
          cmd     = CMD_LOWPOWER;
          latch   = 1'b1;
        end
      end

      default: begin
        // Query and the unused codes leave the state alone.
      end
    endcase
  end

  assign st_o = ns;

  always_comb begin
    res_o.mode            = mode_code(ns.mode);
    res_o.sensor_cmd      = cmd;
    res_o.clear_latch     = latch;
    res_o.discard_samples = disc;
    res_o.reset_stream    = strm;
    res_o.uptime_sec      = ns.uptime_sec;
    res_o.idle_total      = ns.idle_ticks;
    res_o.burst_total     = ns.burst_ticks;
    res_o.active_total    = ns.active_ticks;
    res_o.burst_count     = ns.bursts_seen;
    res_o.motion_count    = ns.motions_seen;
    res_o.movement_byte   = (ns.motions_seen > {8'd0, MOVEMENT_MAX}) ? MOVEMENT_MAX
                                                                     : ns.motions_seen[7:0];
  end

endmodule

### sv/sensor_power_mode_controller.sv
// Top level of the sensor power-mode controller.
`timescale 1ns / 1ps
// The controller takes one item per clock cycle unless in_stall is high and
// hands back one result for each: the item lands in an input register, and
// the mode logic and counters update as the result enters the output register.
// A full output register holds its result while out_stall is high, and the
// input register then holds its item, so up to two items can be in flight and
// an input transfer completes while a result waits if the input register is
// empty. Uptime seconds are counted beside the millisecond phase, so no divider
// is involved. Configuration writes complete in the cycle they are offered.
module sensor_power_mode_controller
  import spmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_regs_t  cfg;
  ctl_state_t state_r;
  ctl_state_t state_nxt;
  out_item_t  res;
  in_item_t   item_r;
  logic       item_valid_r;
  out_item_t  out_r;
  logic       out_valid_r;
  logic       out_load;
  logic       in_load;

  spmc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  spmc_step u_step (
    .st_i   (state_r),
    .cfg_i  (cfg),
    .item_i (item_r),
    .st_o   (state_nxt),
    .res_o  (res)
  );

  // The output register can take a new result when it is empty or being drained.
  assign out_load = !out_valid_r || !out_stall;
  assign in_stall = item_valid_r && !out_load;
  assign in_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_load) begin
      item_valid_r <= 1'b1;
    end else if (out_load) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode           <= ST_BURST;
      state_r.streaming      <= 1'b0;
      state_r.timeout_armed  <= 1'b1;
      state_r.timeout_left   <= TIMEOUT_RESET;
      state_r.heartbeat_left <= HEARTBEAT_RESET;
      state_r.ms_sub         <= '0;
      state_r.uptime_sec     <= '0;
      state_r.idle_ticks     <= '0;
      state_r.burst_ticks    <= '0;
      state_r.active_ticks   <= '0;
      state_r.bursts_seen    <= 16'd1;
      state_r.motions_seen   <= '0;
    end else if (item_valid_r && out_load) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid_r && out_load) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Streaming can only be on while the block sits in active mode.
  a_stream_active: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.streaming |-> state_r.mode == ST_ACTIVE)
    else $error("streaming flag set outside active mode");

  // A held item must stay in the input register until it moves on.
  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid_r && !out_load) |=> item_valid_r && $stable(item_r))
    else $error("held input item lost");

  // The millisecond phase of the uptime stays within one second.
  a_ms_phase: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.ms_sub <= MS_PER_S_LAST)
    else $error("uptime millisecond phase out of range");

endmodule
